FILE: src/i2cbe_pkg.sv
package i2cbe_pkg;

    localparam int unsigned OP_WIDTH   = 3;
    localparam int unsigned BYTE_WIDTH = 8;
    localparam int unsigned STEP_WIDTH = 6;
    localparam int unsigned QT_WIDTH   = 16;

    localparam logic [OP_WIDTH-1:0] OP_IDLE    = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_START   = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_RESTART = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_STOP    = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_WRITE   = 3'd4;
    localparam logic [OP_WIDTH-1:0] OP_READ    = 3'd5;
    localparam logic [OP_WIDTH-1:0] OP_ACK     = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_NACK    = 3'd7;

    localparam logic [STEP_WIDTH-1:0] STEP_BYTE_END = 6'd32;
    localparam logic [STEP_WIDTH-1:0] STEP_ACK_HIGH = 6'd34;
    localparam logic [STEP_WIDTH-1:0] STEP_SHORT_END = 6'd4;
    localparam logic [STEP_WIDTH-1:0] STEP_WRITE_END = 6'd36;

    typedef struct packed {
        logic                  is_cmd;
        logic [OP_WIDTH-1:0]   op;
        logic [BYTE_WIDTH-1:0] data;
        logic                  sda;
    } item_t;

endpackage

FILE: src/i2c_master_bit_engine.sv
// I2C master pin sequencer. Each input beat is a tick (mode 0, carrying the
// sampled SDA level) or a command; a command is ignored while a sequence runs.
// Every accepted beat yields one result beat with the SCL/SDA release levels,
// busy, done, the last write's ACK and the last read byte. One beat per cycle
// in each direction while in_stall and out_stall are low; an input beat is
// written into the two-entry input queue and, when the output can take it,
// popped through the sequencer update into the output register that drives
// the result beat. Write quarter_ticks only while no beat is in flight.
module i2c_master_bit_engine
#(
    parameter int unsigned DIVIDER_WIDTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [i2cbe_pkg::QT_WIDTH-1:0]   cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [i2cbe_pkg::OP_WIDTH-1:0]   mode,
    input  logic [i2cbe_pkg::BYTE_WIDTH-1:0] data_byte,
    input  logic                             sda_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             scl_release,
    output logic                             sda_release,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             ack_bit,
    output logic [i2cbe_pkg::BYTE_WIDTH-1:0] read_byte
);

    logic [i2cbe_pkg::QT_WIDTH-1:0] qt_reg;
    logic [i2cbe_pkg::QT_WIDTH-1:0] qt_next;
    logic                           q_valid;
    logic                           q_pop;
    i2cbe_pkg::item_t               q_item;

    assign qt_next = cfg_wr_en ? cfg_wr_data : qt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qt_reg <= i2cbe_pkg::QT_WIDTH'(125);
        else
            qt_reg <= qt_next;
    end

    i2cbe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .data_byte (data_byte),
        .sda_in    (sda_in),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    i2cbe_back #(
        .DIVIDER_WIDTH (DIVIDER_WIDTH)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .quarter_ticks (qt_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scl_release   (scl_release),
        .sda_release   (sda_release),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .ack_bit       (ack_bit),
        .read_byte     (read_byte)
    );

endmodule

FILE: src/i2cbe_front.sv
module i2cbe_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [i2cbe_pkg::OP_WIDTH-1:0]   mode,
    input  logic [i2cbe_pkg::BYTE_WIDTH-1:0] data_byte,
    input  logic                           sda_in,
    output logic                           q_valid,
    output i2cbe_pkg::item_t               q_item,
    input  logic                           q_pop
);

    i2cbe_pkg::item_t ent_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;
    i2cbe_pkg::item_t new_item;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.is_cmd = (mode != i2cbe_pkg::OP_IDLE);
        new_item.op     = mode;
        new_item.data   = data_byte;
        new_item.sda    = sda_in;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

FILE: src/i2cbe_back.sv
module i2cbe_back
#(
    parameter int unsigned DIVIDER_WIDTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [i2cbe_pkg::QT_WIDTH-1:0]   quarter_ticks,
    input  logic                             q_valid,
    input  i2cbe_pkg::item_t                 q_item,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             scl_release,
    output logic                             sda_release,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             ack_bit,
    output logic [i2cbe_pkg::BYTE_WIDTH-1:0] read_byte
);

    localparam int unsigned PW = (DIVIDER_WIDTH + 1 > i2cbe_pkg::QT_WIDTH + 1)
                                 ? DIVIDER_WIDTH + 1 : i2cbe_pkg::QT_WIDTH + 1;

    logic [i2cbe_pkg::OP_WIDTH-1:0]   op_reg,    op_next;
    logic [i2cbe_pkg::STEP_WIDTH-1:0] step_reg,  step_next;
    logic [DIVIDER_WIDTH-1:0]         div_reg,   div_next;
    logic [i2cbe_pkg::BYTE_WIDTH-1:0] shift_reg, shift_next;
    logic [i2cbe_pkg::BYTE_WIDTH-1:0] rx_reg,    rx_next;
    logic                             scl_reg,   scl_next;
    logic                             sda_reg,   sda_next;
    logic                             ack_reg,   ack_next;

    logic                             out_valid_reg, out_valid_next;
    logic                             o_scl_reg, o_sda_reg, o_busy_reg, o_done_reg, o_ack_reg;
    logic [i2cbe_pkg::BYTE_WIDTH-1:0] o_rx_reg;

    logic [PW-1:0]                    qt_ext;
    logic [PW-1:0]                    limit;
    logic [PW-1:0]                    period;
    logic [PW-1:0]                    div_inc;
    logic                             wrap;
    logic                             active;
    logic                             start_cmd;
    logic                             tick_adv;
    logic                             apply;
    logic                             done;

    logic [i2cbe_pkg::OP_WIDTH-1:0]   b_op;
    logic [i2cbe_pkg::STEP_WIDTH-1:0] b_step;
    logic [i2cbe_pkg::BYTE_WIDTH-1:0] b_shift;
    logic [i2cbe_pkg::BYTE_WIDTH-1:0] b_rx;
    logic [1:0]                       b_phase;
    logic [2:0]                       b_bit;
    logic                             b_scl, b_sda, b_ack, b_end;
    logic [i2cbe_pkg::BYTE_WIDTH-1:0] b_rx_out;

    assign q_pop     = q_valid && (!out_valid_reg || !out_stall);
    assign active    = (op_reg != i2cbe_pkg::OP_IDLE);
    assign start_cmd = q_pop && q_item.is_cmd && !active;

    always_comb
    begin
        qt_ext  = PW'(quarter_ticks);
        limit   = PW'(1) << DIVIDER_WIDTH;
        if (quarter_ticks == '0)
            period = PW'(1);
        else if (qt_ext > limit)
            period = limit;
        else
            period = qt_ext;
        div_inc  = PW'(div_reg) + PW'(1);
        wrap     = (div_inc >= period);
        tick_adv = q_pop && !q_item.is_cmd && active;
    end

    always_comb
    begin
        b_op    = start_cmd ? q_item.op : op_reg;
        b_step  = start_cmd ? '0 : step_reg + 1'b1;
        b_shift = (start_cmd && q_item.op == i2cbe_pkg::OP_WRITE) ? q_item.data : shift_reg;
        b_rx    = (start_cmd && q_item.op == i2cbe_pkg::OP_READ) ? '0 : rx_reg;
        b_phase = b_step[1:0];
        b_bit   = b_step[4:2];
        b_scl    = scl_reg;
        b_sda    = sda_reg;
        b_ack    = ack_reg;
        b_rx_out = b_rx;
        b_end    = 1'b0;
        unique case (b_op)
            i2cbe_pkg::OP_START:
            begin
                if (b_step == '0)
                begin
                    b_scl = 1'b1;
                    b_sda = 1'b1;
                end
                else if (b_step == 6'd2)
                    b_sda = 1'b0;
                b_end = (b_step >= i2cbe_pkg::STEP_SHORT_END);
            end
            i2cbe_pkg::OP_RESTART, i2cbe_pkg::OP_STOP:
            begin
                if (b_step == '0)
                    b_scl = 1'b0;
                else if (b_step == 6'd1)
                    b_sda = (b_op == i2cbe_pkg::OP_RESTART);
                else if (b_step == 6'd2)
                    b_scl = 1'b1;
                else if (b_step == 6'd3)
                    b_sda = (b_op != i2cbe_pkg::OP_RESTART);
                b_end = (b_step >= i2cbe_pkg::STEP_SHORT_END);
            end
            i2cbe_pkg::OP_ACK, i2cbe_pkg::OP_NACK:
            begin
                if (b_step == '0)
                    b_scl = 1'b0;
                else if (b_step == 6'd1)
                    b_sda = (b_op == i2cbe_pkg::OP_NACK);
                else if (b_step == 6'd2)
                    b_scl = 1'b1;
                b_end = (b_step >= i2cbe_pkg::STEP_SHORT_END);
            end
            i2cbe_pkg::OP_WRITE:
            begin
                if (b_step < i2cbe_pkg::STEP_BYTE_END)
                begin
                    if (b_phase == 2'd0)
                        b_scl = 1'b0;
                    else if (b_phase == 2'd1)
                        b_sda = b_shift[~b_bit];
                    else if (b_phase == 2'd2)
                        b_scl = 1'b1;
                end
                else if (b_step == i2cbe_pkg::STEP_BYTE_END)
                begin
                    b_scl = 1'b0;
                    b_sda = 1'b1;
                end
                else if (b_step == i2cbe_pkg::STEP_ACK_HIGH)
                    b_scl = 1'b1;
                else if (b_step >= i2cbe_pkg::STEP_WRITE_END)
                begin
                    b_ack = q_item.sda;
                    b_end = 1'b1;
                end
            end
            i2cbe_pkg::OP_READ:
            begin
                if (b_step >= i2cbe_pkg::STEP_BYTE_END)
                    b_end = 1'b1;
                else if (b_phase == 2'd0)
                begin
                    b_scl = 1'b0;
                    b_sda = 1'b1;
                end
                else if (b_phase == 2'd2)
                    b_scl = 1'b1;
                else if (b_phase == 2'd3)
                    b_rx_out[~b_bit] = b_rx[~b_bit] | q_item.sda;
            end
            default:
                b_end = 1'b1;
        endcase
    end

    always_comb
    begin
        op_next    = op_reg;
        step_next  = step_reg;
        div_next   = div_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        done       = 1'b0;
        apply      = 1'b0;
        priority if (start_cmd)
        begin
            op_next    = q_item.op;
            step_next  = '0;
            div_next   = '0;
            shift_next = b_shift;
            apply      = 1'b1;
        end
        else if (tick_adv)
        begin
            if (wrap)
            begin
                div_next  = '0;
                step_next = b_step;
                apply     = 1'b1;
                if (b_end)
                begin
                    op_next   = i2cbe_pkg::OP_IDLE;
                    step_next = '0;
                    done      = 1'b1;
                end
            end
            else
                div_next = div_inc[DIVIDER_WIDTH-1:0];
        end
        if (apply)
        begin
            scl_next = b_scl;
            sda_next = b_sda;
            ack_next = b_ack;
            rx_next  = b_rx_out;
        end
    end

    always_comb
    begin
        if (q_pop)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= i2cbe_pkg::OP_IDLE;
            step_reg      <= '0;
            div_reg       <= '0;
            shift_reg     <= '0;
            rx_reg        <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_reg        <= op_next;
            step_reg      <= step_next;
            div_reg       <= div_next;
            shift_reg     <= shift_next;
            rx_reg        <= rx_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_reg       <= ack_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            o_scl_reg  <= scl_next;
            o_sda_reg  <= sda_next;
            o_busy_reg <= (op_next != i2cbe_pkg::OP_IDLE);
            o_done_reg <= done;
            o_ack_reg  <= ack_next;
            o_rx_reg   <= rx_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_release = o_scl_reg;
    assign sda_release = o_sda_reg;
    assign busy_res    = o_busy_reg;
    assign done_res    = o_done_reg;
    assign ack_bit     = o_ack_reg;
    assign read_byte   = o_rx_reg;

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !active |-> (step_reg == '0) && (div_reg == '0))
        else $error("idle sequencer holds a nonzero step or divider");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= i2cbe_pkg::STEP_WRITE_END)
        else $error("quarter step ran past the longest sequence");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && o_done_reg |-> !o_busy_reg)
        else $error("done beat reports busy");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && done |=> !active)
        else $error("sequencer still active after done");

endmodule

FILE: sim/i2c_master_bit_engine_tb.sv
module i2c_master_bit_engine_tb;

    localparam int unsigned DIV_W          = 16;
    localparam int unsigned DIV_LIMIT      = 1 << DIV_W;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned ITEM_GOAL      = 1500;
    localparam logic [i2cbe_pkg::OP_WIDTH-1:0] MODE_TICK = i2cbe_pkg::OP_IDLE;

    typedef struct packed {
        logic                             scl;
        logic                             sda;
        logic                             busy;
        logic                             done;
        logic                             ack;
        logic [i2cbe_pkg::BYTE_WIDTH-1:0] rbyte;
    } pins_t;

    typedef struct packed {
        logic                             cfg;
        logic [i2cbe_pkg::QT_WIDTH-1:0]   qlen;
        logic [i2cbe_pkg::OP_WIDTH-1:0]   m;
        logic [i2cbe_pkg::BYTE_WIDTH-1:0] d;
        logic                             s;
        logic                             settle;
        logic                             typed;
        pins_t                            want;
    } plan_row_t;

    localparam pins_t PINS_AT_RESET = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00};
    localparam pins_t PINS_STARTING = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
    localparam pins_t PINS_NONE     = '0;
    localparam int    PLAN_ROWS     = 23;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{1'b0, 16'd0, MODE_TICK,             8'h00, 1'b1, 1'b0, 1'b1, PINS_AT_RESET},
        '{1'b0, 16'd0, MODE_TICK,             8'hFF, 1'b0, 1'b0, 1'b1, PINS_AT_RESET},
        '{1'b0, 16'd0, i2cbe_pkg::OP_START,   8'hFF, 1'b0, 1'b0, 1'b1, PINS_STARTING},
        '{1'b0, 16'd0, i2cbe_pkg::OP_WRITE,   8'hFF, 1'b1, 1'b0, 1'b1, PINS_STARTING},
        '{1'b0, 16'd0, i2cbe_pkg::OP_NACK,    8'h00, 1'b0, 1'b0, 1'b1, PINS_STARTING},
        '{1'b0, 16'd0, MODE_TICK,             8'h00, 1'b1, 1'b1, 1'b0, PINS_NONE},
        '{1'b1, 16'd0, MODE_TICK,             8'h00, 1'b0, 1'b0, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_WRITE,   8'hFF, 1'b0, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_WRITE,   8'h00, 1'b1, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_READ,    8'hFF, 1'b1, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_READ,    8'h00, 1'b0, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_RESTART, 8'h00, 1'b1, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_ACK,     8'h00, 1'b0, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_NACK,    8'h00, 1'b1, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_STOP,    8'h00, 1'b0, 1'b1, 1'b0, PINS_NONE},
        '{1'b1, 16'd1, MODE_TICK,             8'h00, 1'b0, 1'b0, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_START,   8'h00, 1'b1, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_WRITE,   8'hA5, 1'b0, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_READ,    8'h00, 1'b1, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_NACK,    8'h00, 1'b1, 1'b1, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_STOP,    8'h00, 1'b0, 1'b1, 1'b0, PINS_NONE},
        '{1'b1, 16'd2, MODE_TICK,             8'h00, 1'b0, 1'b0, 1'b0, PINS_NONE},
        '{1'b0, 16'd0, i2cbe_pkg::OP_WRITE,   8'h3C, 1'b1, 1'b1, 1'b0, PINS_NONE}
    };

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [i2cbe_pkg::QT_WIDTH-1:0]   cfg_wr_data;
    logic                             in_valid;
    logic                             in_stall;
    logic [i2cbe_pkg::OP_WIDTH-1:0]   mode;
    logic [i2cbe_pkg::BYTE_WIDTH-1:0] data_byte;
    logic                             sda_in;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             scl_release;
    logic                             sda_release;
    logic                             busy_res;
    logic                             done_res;
    logic                             ack_bit;
    logic [i2cbe_pkg::BYTE_WIDTH-1:0] read_byte;

    // predictor state
    logic [i2cbe_pkg::QT_WIDTH-1:0]   quarter_len;
    logic [i2cbe_pkg::OP_WIDTH-1:0]   seq_op;
    logic [i2cbe_pkg::STEP_WIDTH-1:0] seq_quarter;
    int unsigned                      seq_div;
    logic [i2cbe_pkg::BYTE_WIDTH-1:0] tx_shift;
    logic [i2cbe_pkg::BYTE_WIDTH-1:0] rx_shift;
    logic                             scl_lvl;
    logic                             sda_lvl;
    logic                             ack_lvl;

    pins_t       pin_state_q [$];
    pins_t       head_pins;
    int unsigned errors;
    int unsigned beats_sent;
    int unsigned results_checked;
    int unsigned quiet_cycles;
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned cmd_runs [8];

    i2c_master_bit_engine #(
        .DIVIDER_WIDTH (DIV_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .data_byte   (data_byte),
        .sda_in      (sda_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scl_release (scl_release),
        .sda_release (sda_release),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .ack_bit     (ack_bit),
        .read_byte   (read_byte)
    );

    always #6 clk = ~clk;

    function automatic logic quarter_edge(input logic [i2cbe_pkg::STEP_WIDTH-1:0] q,
                                          input logic s);
        logic [2:0] b;
        logic [1:0] p;
        b = q[4:2];
        p = q[1:0];
        case (seq_op)
            i2cbe_pkg::OP_START:
            begin
                if (q == 0)
                begin
                    scl_lvl = 1'b1;
                    sda_lvl = 1'b1;
                end
                else if (q == 2)
                    sda_lvl = 1'b0;
                return q >= i2cbe_pkg::STEP_SHORT_END;
            end
            i2cbe_pkg::OP_RESTART, i2cbe_pkg::OP_STOP:
            begin
                if (q == 0)
                    scl_lvl = 1'b0;
                else if (q == 1)
                    sda_lvl = (seq_op == i2cbe_pkg::OP_RESTART);
                else if (q == 2)
                    scl_lvl = 1'b1;
                else if (q == 3)
                    sda_lvl = (seq_op == i2cbe_pkg::OP_STOP);
                return q >= i2cbe_pkg::STEP_SHORT_END;
            end
            i2cbe_pkg::OP_ACK, i2cbe_pkg::OP_NACK:
            begin
                if (q == 0)
                    scl_lvl = 1'b0;
                else if (q == 1)
                    sda_lvl = (seq_op == i2cbe_pkg::OP_NACK);
                else if (q == 2)
                    scl_lvl = 1'b1;
                return q >= i2cbe_pkg::STEP_SHORT_END;
            end
            i2cbe_pkg::OP_WRITE:
            begin
                if (q < i2cbe_pkg::STEP_BYTE_END)
                begin
                    if (p == 0)
                        scl_lvl = 1'b0;
                    else if (p == 1)
                        sda_lvl = tx_shift[3'd7 - b];
                    else if (p == 2)
                        scl_lvl = 1'b1;
                    return 1'b0;
                end
                if (q == i2cbe_pkg::STEP_BYTE_END)
                begin
                    scl_lvl = 1'b0;
                    sda_lvl = 1'b1;
                end
                else if (q == i2cbe_pkg::STEP_ACK_HIGH)
                    scl_lvl = 1'b1;
                else if (q >= i2cbe_pkg::STEP_WRITE_END)
                begin
                    ack_lvl = s;
                    return 1'b1;
                end
                return 1'b0;
            end
            i2cbe_pkg::OP_READ:
            begin
                if (q >= i2cbe_pkg::STEP_BYTE_END)
                    return 1'b1;
                if (p == 0)
                begin
                    scl_lvl = 1'b0;
                    sda_lvl = 1'b1;
                end
                else if (p == 2)
                    scl_lvl = 1'b1;
                else if (p == 3)
                    rx_shift[3'd7 - b] = rx_shift[3'd7 - b] | s;
                return 1'b0;
            end
            default:
                return 1'b1;
        endcase
    endfunction

    function automatic pins_t bus_model_step(input logic [i2cbe_pkg::OP_WIDTH-1:0] m,
                                             input logic [i2cbe_pkg::BYTE_WIDTH-1:0] d,
                                             input logic s);
        pins_t       r;
        int unsigned period;
        logic        fin;
        fin = 1'b0;
        if (m != MODE_TICK)
        begin
            if (seq_op == i2cbe_pkg::OP_IDLE)
            begin
                seq_op      = m;
                seq_quarter = '0;
                seq_div     = 0;
                if (m == i2cbe_pkg::OP_WRITE)
                    tx_shift = d;
                if (m == i2cbe_pkg::OP_READ)
                    rx_shift = '0;
                void'(quarter_edge('0, s));
            end
        end
        else if (seq_op != i2cbe_pkg::OP_IDLE)
        begin
            period = (quarter_len == 0) ? 1 : quarter_len;
            if (period > DIV_LIMIT)
                period = DIV_LIMIT;
            seq_div++;
            if (seq_div >= period)
            begin
                seq_div     = 0;
                seq_quarter = seq_quarter + 1'b1;
                if (quarter_edge(seq_quarter, s))
                begin
                    seq_op      = i2cbe_pkg::OP_IDLE;
                    seq_quarter = '0;
                    fin         = 1'b1;
                end
            end
        end
        r.scl   = scl_lvl;
        r.sda   = sda_lvl;
        r.busy  = (seq_op != i2cbe_pkg::OP_IDLE);
        r.done  = fin;
        r.ack   = ack_lvl;
        r.rbyte = rx_shift;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        errors++;
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 what, results_checked, got, want);
    endtask

    task automatic send_beat(input logic [i2cbe_pkg::OP_WIDTH-1:0] m,
                             input logic [i2cbe_pkg::BYTE_WIDTH-1:0] d,
                             input logic s, input logic typed, input pins_t typed_pins);
        pins_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        data_byte <= d;
        sda_in    <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (m != MODE_TICK && seq_op == i2cbe_pkg::OP_IDLE)
            cmd_runs[m]++;
        want = bus_model_step(m, d, s);
        pin_state_q.push_back(typed ? typed_pins : want);
        beats_sent++;
    endtask

    task automatic drive_beat(input logic [i2cbe_pkg::OP_WIDTH-1:0] m,
                              input logic [i2cbe_pkg::BYTE_WIDTH-1:0] d,
                              input logic s);
        send_beat(m, d, s, 1'b0, PINS_NONE);
    endtask

    task automatic hold_for_results();
        in_valid <= 1'b0;
        while (pin_state_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_quarter(input logic [i2cbe_pkg::QT_WIDTH-1:0] v);
        hold_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        quarter_len = v;
    endtask

    task automatic run_cmd(input logic [i2cbe_pkg::OP_WIDTH-1:0] m,
                           input logic [i2cbe_pkg::BYTE_WIDTH-1:0] d);
        if ($urandom_range(99) < 2)
            hold_for_results();
        drive_beat(m, d, 1'($urandom));
        while (seq_op != i2cbe_pkg::OP_IDLE)
        begin
            // drop a stray command into the running sequence now and then
            if ($urandom_range(99) < 4)
                drive_beat(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom));
            else
                drive_beat(MODE_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic bus_transaction();
        int unsigned nbytes;
        int unsigned k;
        if ($urandom_range(99) < 82)
        begin
            run_cmd(i2cbe_pkg::OP_START, 8'($urandom));
            nbytes = $urandom_range(1, 3);
            for (k = 0; k < nbytes; k++)
            begin
                if ($urandom_range(99) < 15)
                    run_cmd(i2cbe_pkg::OP_RESTART, 8'($urandom));
                if ($urandom_range(1) == 1)
                    run_cmd(i2cbe_pkg::OP_WRITE, 8'($urandom));
                else
                begin
                    run_cmd(i2cbe_pkg::OP_READ, 8'($urandom));
                    run_cmd(($urandom_range(1) == 1) ? i2cbe_pkg::OP_ACK : i2cbe_pkg::OP_NACK,
                            8'($urandom));
                end
            end
            run_cmd(i2cbe_pkg::OP_STOP, 8'($urandom));
        end
        else
        begin
            nbytes = $urandom_range(2, 8);
            for (k = 0; k < nbytes; k++)
                drive_beat(3'($urandom), 8'($urandom), 1'($urandom));
            while (seq_op != i2cbe_pkg::OP_IDLE)
                drive_beat(MODE_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_traffic(input int unsigned beats);
        int unsigned target;
        target = beats_sent + beats;
        while (beats_sent < target)
            bus_transaction();
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pin_state_q.size() == 0)
                note_mismatch("beat with nothing expected", 8'h00, 8'h00);
            else
            begin
                head_pins = pin_state_q.pop_front();
                results_checked++;
                if (scl_release !== head_pins.scl)
                    note_mismatch("scl_release", 8'(scl_release), 8'(head_pins.scl));
                if (sda_release !== head_pins.sda)
                    note_mismatch("sda_release", 8'(sda_release), 8'(head_pins.sda));
                if (busy_res !== head_pins.busy)
                    note_mismatch("busy_res", 8'(busy_res), 8'(head_pins.busy));
                if (done_res !== head_pins.done)
                    note_mismatch("done_res", 8'(done_res), 8'(head_pins.done));
                if (ack_bit !== head_pins.ack)
                    note_mismatch("ack_bit", 8'(ack_bit), 8'(head_pins.ack));
                if (read_byte !== head_pins.rbyte)
                    note_mismatch("read_byte", read_byte, head_pins.rbyte);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int        i;
        plan_row_t row;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        mode          = MODE_TICK;
        data_byte     = '0;
        sda_in        = 1'b1;
        quarter_len   = 16'd125;
        seq_op        = i2cbe_pkg::OP_IDLE;
        seq_quarter   = '0;
        seq_div       = 0;
        tx_shift      = '0;
        rx_shift      = '0;
        scl_lvl       = 1'b1;
        sda_lvl       = 1'b1;
        ack_lvl       = 1'b0;
        send_idle_pct = 16;
        stall_pct     = 61;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PLAN_ROWS; i++)
        begin
            row = PLAN[i];
            if (row.cfg)
                set_quarter(row.qlen);
            else
            begin
                send_beat(row.m, row.d, row.s, row.typed, row.want);
                if (row.settle)
                    while (seq_op != i2cbe_pkg::OP_IDLE)
                        drive_beat(MODE_TICK, 8'($urandom), row.s);
            end
        end

        set_quarter(16'd1);
        run_traffic(80);
        set_quarter(16'd2);
        run_traffic(60);

        hold_for_results();
        send_idle_pct = 61;
        stall_pct     = 16;
        set_quarter(16'd0);
        run_traffic(80);
        set_quarter(16'd3);
        run_traffic(60);

        hold_for_results();
        send_idle_pct = 0;
        stall_pct     = 0;
        set_quarter(16'($urandom_range(1, 2)));
        run_traffic((ITEM_GOAL > beats_sent) ? ITEM_GOAL - beats_sent : 0);

        // longest quarter: open a start and tick into its first quarter
        set_quarter(16'hFFFF);
        drive_beat(MODE_TICK, 8'($urandom), 1'($urandom));
        drive_beat(i2cbe_pkg::OP_START, 8'($urandom), 1'($urandom));
        repeat (24)
            drive_beat(MODE_TICK, 8'($urandom), 1'($urandom));

        hold_for_results();
        repeat (8) @(posedge clk);

        $display("%0d beats sent, %0d results checked, quarter lengths 125, 0 to 3 and 65535",
                 beats_sent, results_checked);
        $display("sequences run: start %0d restart %0d stop %0d write %0d read %0d ack %0d nack %0d",
                 cmd_runs[i2cbe_pkg::OP_START], cmd_runs[i2cbe_pkg::OP_RESTART],
                 cmd_runs[i2cbe_pkg::OP_STOP], cmd_runs[i2cbe_pkg::OP_WRITE],
                 cmd_runs[i2cbe_pkg::OP_READ], cmd_runs[i2cbe_pkg::OP_ACK],
                 cmd_runs[i2cbe_pkg::OP_NACK]);
        if (errors == 0 && pin_state_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
src/i2cbe_pkg.sv
src/i2cbe_front.sv
src/i2cbe_back.sv
src/i2c_master_bit_engine.sv
sim/i2c_master_bit_engine_tb.sv
